@@ rtl/ptdc_pkg.sv @@
// Shared types, codes and defaults for the priority ticket deque with cursor.
`default_nettype none

package ptdc_pkg;

	// Default number of ring slots.
	localparam int QUEUE_DEPTH_DEF = 16;

	// Command codes.
	localparam logic CMD_REGISTER = 1'b0;
	localparam logic CMD_CALL     = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_ALL_CALLED = 2'd2,
		ST_FULL       = 2'd3
	} status_t;

	typedef struct packed {
		logic        command;
		logic [15:0] ticket_number;
		logic [31:0] patient_tag;
		logic        is_priority;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic        current_valid;
		logic [15:0] current_ticket;
		logic [31:0] current_patient;
		logic        prev_valid;
		logic [15:0] prev_ticket;
		logic [31:0] prev_patient;
		logic        next_valid;
		logic [15:0] next_ticket;
		logic [31:0] next_patient;
	} result_t;

	// One stored ring entry.
	typedef struct packed {
		logic [15:0] ticket;
		logic [31:0] patient;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Status and view flags handed from the ring engine to the result stage.
	typedef struct packed {
		status_t status;
		logic    cur_valid;
		logic    prev_valid;
		logic    next_valid;
	} flags_t;

endpackage

`default_nettype wire

@@ rtl/ptdc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ptdc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/ptdc_engine.sv @@
// Ring index state, insert and cursor update, and view slot selection.
`default_nettype none

module ptdc_engine #(
	parameter int QUEUE_DEPTH = ptdc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  ptdc_pkg::item_t                item,
	output logic                           wr_en,
	output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
	output ptdc_pkg::entry_t               wr_data,
	output logic [$clog2(QUEUE_DEPTH)-1:0] cur_slot,
	output logic [$clog2(QUEUE_DEPTH)-1:0] prev_slot,
	output logic [$clog2(QUEUE_DEPTH)-1:0] next_slot,
	output ptdc_pkg::flags_t               flags
);

	import ptdc_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int POS_W = IDX_W + 1;
	localparam int SUM_W = CNT_W + 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

	logic [IDX_W-1:0] head_q, head_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [IDX_W-1:0] cursor_q, cursor_n;
	logic             cursor_valid_q, cursor_valid_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [SUM_W-1:0] tail_sum;
	logic [IDX_W-1:0] tail_slot;
	status_t          status;

	function automatic logic [IDX_W-1:0] slot_fwd(input logic [IDX_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] slot_back(input logic [IDX_W-1:0] s);
		return (s == '0) ? LAST_SLOT : s - IDX_W'(1);
	endfunction

	// Distance of the cursor from the head around the ring.
	function automatic logic [POS_W-1:0] pos_of(input logic [IDX_W-1:0] c,
			input logic [IDX_W-1:0] h);
		logic [POS_W-1:0] ce;
		logic [POS_W-1:0] he;
		ce = POS_W'(c);
		he = POS_W'(h);
		return (c >= h) ? ce - he : ce + POS_W'(QUEUE_DEPTH) - he;
	endfunction

	assign pos_q     = pos_of(cursor_q, head_q);
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		tail_sum[IDX_W-1:0] - LAST_SLOT - IDX_W'(1) : tail_sum[IDX_W-1:0];

	always_comb begin
		head_n         = head_q;
		count_n        = count_q;
		cursor_n       = cursor_q;
		cursor_valid_n = cursor_valid_q;
		status         = ST_OK;
		wr_en          = 1'b0;
		wr_addr        = tail_slot;
		if (item_valid) begin
			if (item.command == CMD_REGISTER) begin
				if (count_q == FULL_CNT) begin
					status = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					count_n = count_q + CNT_W'(1);
					if (count_q == '0) begin
						wr_addr = head_q;
					end else if (item.is_priority) begin
						head_n  = slot_back(head_q);
						wr_addr = head_n;
					end else begin
						wr_addr = tail_slot;
					end
				end
			end else begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else if (!cursor_valid_q) begin
					cursor_n       = head_q;
					cursor_valid_n = 1'b1;
				end else if (pos_q + POS_W'(1) < POS_W'(count_q)) begin
					cursor_n = slot_fwd(cursor_q);
				end else begin
					status = ST_ALL_CALLED;
				end
			end
		end
	end

	assign wr_data = '{ticket: item.ticket_number, patient: item.patient_tag};

	// Views are taken from the state as it stands after this transaction.
	assign pos_n     = pos_of(cursor_n, head_n);
	assign cur_slot  = cursor_n;
	assign prev_slot = slot_back(cursor_n);
	assign next_slot = cursor_valid_n ? slot_fwd(cursor_n) : head_n;

	always_comb begin
		flags.status    = status;
		flags.cur_valid = cursor_valid_n;
		flags.prev_valid = cursor_valid_n && (pos_n != '0);
		flags.next_valid = cursor_valid_n ? (pos_n + POS_W'(1) < POS_W'(count_n))
			: (count_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			count_q        <= '0;
			cursor_q       <= '0;
			cursor_valid_q <= 1'b0;
		end else if (item_valid) begin
			head_q         <= head_n;
			count_q        <= count_n;
			cursor_q       <= cursor_n;
			cursor_valid_q <= cursor_valid_n;
		end
	end

endmodule

`default_nettype wire

@@ rtl/priority_ticket_deque_cursor.sv @@
// Top level of the priority ticket deque with serving cursor.
//
//   Channel   Ports                 Direction  Handshake
//   command   start, busy, item     in         taken when start is high and busy is low
//   result    strobe, result        out        one cycle per result, cannot be held off
//
// One transaction is taken in every clock cycle. Its result passes the input register, the
// ring update in the engine, and the registered read of the three entry RAM copies (one for
// each of the current, previous and next views), and appears with strobe high for a single
// cycle. Reset clears the head, count and cursor at once; the entry RAMs are not cleared,
// since only slots that hold stored entries are ever reported. The receiver cannot stall,
// so busy stays low throughout.
`default_nettype none

module priority_ticket_deque_cursor #(
	parameter int QUEUE_DEPTH = ptdc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ptdc_pkg::item_t   item,
	output logic              strobe,
	output ptdc_pkg::result_t result
);

	import ptdc_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	logic             accept;
	logic             valid_s1;
	item_t            item_s1;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic [IDX_W-1:0] cur_slot, prev_slot, next_slot;
	flags_t           flags;

	logic             valid_s2;
	flags_t           flags_s2;
	entry_t           wr_data_s2;
	logic             hit_cur_s2, hit_prev_s2, hit_next_s2;

	logic [ENTRY_W-1:0] cur_rd, prev_rd, next_rd;
	entry_t           cur_view, prev_view, next_view;

	// The block never holds off a transaction.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	ptdc_engine #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(valid_s1),
		.item      (item_s1),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.cur_slot  (cur_slot),
		.prev_slot (prev_slot),
		.next_slot (next_slot),
		.flags     (flags)
	);

	// Three copies of the ring storage, all written alike, each read for one view.
	ptdc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram_cur (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(cur_slot),
		.rd_data(cur_rd)
	);

	ptdc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram_prev (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(prev_slot),
		.rd_data(prev_rd)
	);

	ptdc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram_next (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(next_slot),
		.rd_data(next_rd)
	);

	// Result stage. The RAM returns the old contents when a slot is read in the
	// cycle it is written, so the freshly written entry is carried alongside and
	// chosen wherever a view points at that slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			flags_s2    <= flags;
			wr_data_s2  <= wr_data;
			hit_cur_s2  <= wr_en && (wr_addr == cur_slot);
			hit_prev_s2 <= wr_en && (wr_addr == prev_slot);
			hit_next_s2 <= wr_en && (wr_addr == next_slot);
		end
	end

	// A view that is not valid reports zero in its ticket and patient fields.
	function automatic entry_t pick_view(input logic vld, input logic hit,
			input entry_t fresh, input logic [ENTRY_W-1:0] stored);
		entry_t e;
		e = hit ? fresh : entry_t'(stored);
		return vld ? e : '0;
	endfunction

	assign cur_view  = pick_view(flags_s2.cur_valid, hit_cur_s2, wr_data_s2, cur_rd);
	assign prev_view = pick_view(flags_s2.prev_valid, hit_prev_s2, wr_data_s2, prev_rd);
	assign next_view = pick_view(flags_s2.next_valid, hit_next_s2, wr_data_s2, next_rd);

	assign strobe = valid_s2;

	always_comb begin
		result.status          = flags_s2.status;
		result.current_valid   = flags_s2.cur_valid;
		result.current_ticket  = cur_view.ticket;
		result.current_patient = cur_view.patient;
		result.prev_valid      = flags_s2.prev_valid;
		result.prev_ticket     = prev_view.ticket;
		result.prev_patient    = prev_view.patient;
		result.next_valid      = flags_s2.next_valid;
		result.next_ticket     = next_view.ticket;
		result.next_patient    = next_view.patient;
	end

	// Every result stems from an accepted transaction, carried through the input and result registers.
	a_strobe_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(accept, 2))
		else $error("result strobe without a matching transaction");

	// An empty ring can never have a cursor.
	a_empty_no_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.status == ST_EMPTY) |-> !result.current_valid)
		else $error("cursor reported on an empty ring");

	// An entry before the cursor implies a cursor.
	a_prev_needs_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.prev_valid) |-> result.current_valid)
		else $error("previous entry reported without a cursor");

	// Only a register transaction may be rejected as full, and it writes nothing.
	a_full_only_on_register: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && flags.status == ST_FULL) |->
			(item_s1.command == CMD_REGISTER && !wr_en))
		else $error("full status on a call, or a write on a rejected insert");

endmodule

`default_nettype wire
